@@ design/ssm_pkg.sv @@
// ----------------------------------------------------------------------------
// ssm_pkg: shared types and constants of the serial stream mux transmitter
// Actions, send phases, select and escape bytes, queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none
package ssm_pkg;
    localparam int QueueDepth = 256;
    localparam int PacketMax  = 32;
    localparam int QAW = $clog2(QueueDepth);
    localparam int QCW = $clog2(QueueDepth + 1);
    localparam int PAW = $clog2(PacketMax);
    localparam int PLW = $clog2(PacketMax + 2);

    localparam logic [7:0] SEL_APP  = 8'hFE;
    localparam logic [7:0] SEL_DBG  = 8'hFD;
    localparam logic [7:0] ESC_CHAR = 8'hFC;

    typedef enum logic [1:0] {
        ACT_PUSH_APP = 2'd0,
        ACT_PUSH_DBG = 2'd1,
        ACT_END_PKT  = 2'd2,
        ACT_PULL     = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        PH_IDLE, PH_PAD, PH_START, PH_BODY, PH_TRAIL, PH_APPOWED
    } t_phase;

    // one decoded item handed from the front end to the back end
    typedef struct packed {
        t_action    action;
        logic [7:0] data;
        logic [9:0] delay;
    } t_cmd;

    function automatic logic needs_esc(input logic [7:0] b);
        return (b == SEL_APP) || (b == SEL_DBG) || (b == ESC_CHAR);
    endfunction
endpackage
`default_nettype wire

@@ design/ssm_ram.sv @@
// ----------------------------------------------------------------------------
// ssm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ssm_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ design/ssm_front.sv @@
// ----------------------------------------------------------------------------
// ssm_front: input stage and command queue
// Takes input transfers into a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module ssm_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire ssm_pkg::t_cmd i_cmd,
    output logic               o_valid,
    input  wire logic          i_ready,
    output ssm_pkg::t_cmd      o_cmd
);
    import ssm_pkg::*;

    t_cmd       r_q [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !pop) |=> (r_cnt == 2'd2)) else $error("queue count lost");
    a_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_rd == r_wr)) else $error("ptr mismatch");
endmodule
`default_nettype wire

@@ design/ssm_back.sv @@
// ----------------------------------------------------------------------------
// ssm_back: queues, packet gathering and byte sequencer
// Executes one command and presents one result.
// ----------------------------------------------------------------------------
`default_nettype none
module ssm_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire ssm_pkg::t_cmd i_cmd,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic               o_accepted,
    output logic               o_out_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_packet_dropped
);
    import ssm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_GREAD, S_GWAIT, S_GEVAL, S_PREAD, S_PWAIT, S_PEVAL, S_OUT
    } t_seq;

    t_seq r_st, n_st;
    t_cmd r_cmd, n_cmd;

    logic [QAW-1:0] r_ard, n_ard, r_awr, n_awr, r_drd, n_drd, r_dwr, n_dwr;
    logic [QCW-1:0] r_acnt, n_acnt, r_dcnt, n_dcnt;
    logic [PLW-1:0] r_plen, n_plen;
    logic [9:0]     r_pdel, n_pdel, r_pad, n_pad;
    logic           r_prdy, n_prdy, r_cur, n_cur;
    logic [8:0]     r_pend, n_pend;
    t_phase         r_ph, n_ph;
    logic [PLW-1:0] r_sidx, n_sidx;
    logic           r_acc, n_acc, r_ov, n_ov, r_drop, n_drop;
    logic [7:0]     r_ob, n_ob;
    logic           r_owed, n_owed;

    logic           a_we, d_we, p_we;
    logic [QAW-1:0] a_ra, d_ra;
    logic [PAW-1:0] p_wa, p_ra;
    logic [7:0]     a_rd, p_rd, p_wd;
    logic [10:0]    d_wd, d_rd;

    ssm_ram #(.Width(8), .Depth(QueueDepth)) u_app (
        .i_clk, .i_we(a_we), .i_waddr(r_awr), .i_wdata(r_cmd.data),
        .i_raddr(a_ra), .o_rdata(a_rd));
    ssm_ram #(.Width(11), .Depth(QueueDepth)) u_dbg (
        .i_clk, .i_we(d_we), .i_waddr(r_dwr), .i_wdata(d_wd),
        .i_raddr(d_ra), .o_rdata(d_rd));
    ssm_ram #(.Width(8), .Depth(PacketMax)) u_pkt (
        .i_clk, .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd),
        .i_raddr(p_ra), .o_rdata(p_rd));

    function automatic logic [QAW-1:0] inc(input logic [QAW-1:0] p);
        return (32'(p) + 1 >= QueueDepth) ? '0 : p + 1'b1;
    endfunction

    assign o_ready          = (r_st == S_IDLE);
    assign o_valid          = (r_st == S_OUT);
    assign o_accepted       = r_acc;
    assign o_out_valid      = r_ov;
    assign o_out_byte       = r_ob;
    assign o_packet_dropped = r_drop;
    assign a_ra = r_ard;
    assign d_ra = r_drd;
    assign p_wa = r_plen[PAW-1:0];
    assign p_ra = r_sidx[PAW-1:0];
    assign p_wd = d_rd[7:0];
    assign d_wd = (r_cmd.action == ACT_PUSH_DBG) ? {3'b000, r_cmd.data}
                                                 : {1'b1, r_cmd.delay};

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_ob  <= n_ob;
        r_pdel <= n_pdel;
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ard <= '0; r_awr <= '0; r_drd <= '0; r_dwr <= '0;
            r_acnt <= '0; r_dcnt <= '0; r_plen <= '0; r_pad <= '0;
            r_prdy <= 1'b0; r_cur <= 1'b0; r_pend <= '0; r_ph <= PH_IDLE;
            r_sidx <= '0; r_acc <= 1'b0; r_ov <= 1'b0; r_drop <= 1'b0;
            r_owed <= 1'b0;
        end else begin
            r_st <= n_st; r_ard <= n_ard; r_awr <= n_awr; r_drd <= n_drd;
            r_dwr <= n_dwr; r_acnt <= n_acnt; r_dcnt <= n_dcnt; r_plen <= n_plen;
            r_pad <= n_pad; r_prdy <= n_prdy; r_cur <= n_cur; r_pend <= n_pend;
            r_ph <= n_ph; r_sidx <= n_sidx; r_acc <= n_acc; r_ov <= n_ov;
            r_drop <= n_drop; r_owed <= n_owed;
        end
    end

    always_comb begin
        logic [9:0] pad_d;
        logic       app_go;
        n_st = r_st; n_cmd = r_cmd; n_ard = r_ard; n_awr = r_awr; n_drd = r_drd;
        n_dwr = r_dwr; n_acnt = r_acnt; n_dcnt = r_dcnt; n_plen = r_plen;
        n_pdel = r_pdel; n_pad = r_pad; n_prdy = r_prdy; n_cur = r_cur;
        n_pend = r_pend; n_ph = r_ph; n_sidx = r_sidx; n_acc = r_acc; n_ov = r_ov;
        n_ob = r_ob; n_drop = r_drop; n_owed = r_owed;
        a_we = 1'b0; d_we = 1'b0; p_we = 1'b0;
        pad_d  = (r_pad != 10'd0) ? r_pad - 10'd1 : 10'd0;
        app_go = (r_acnt != '0) && ((r_pad != 10'd0) || !r_prdy);
        case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd = i_cmd; n_acc = 1'b0; n_ov = 1'b0; n_ob = 8'h00;
                    n_drop = 1'b0; n_owed = 1'b0;
                    n_st = (i_cmd.action == ACT_PULL) ? S_GREAD : S_OUT;
                    case (i_cmd.action)
                        ACT_PUSH_APP: if (32'(r_acnt) < QueueDepth) n_acc = 1'b1;
                        ACT_PUSH_DBG,
                        ACT_END_PKT:  if (32'(r_dcnt) < QueueDepth) n_acc = 1'b1;
                        default: begin
                            if (r_pend[8]) begin
                                n_ov = 1'b1; n_ob = r_pend[7:0]; n_pend = '0;
                                n_st = S_OUT;
                            end else if (r_ph == PH_APPOWED) begin
                                n_ph = PH_IDLE; n_owed = 1'b1; n_st = S_PREAD;
                            end else if (r_ph != PH_IDLE) begin
                                n_st = S_PREAD;
                            end
                        end
                    endcase
                end
            end
            S_OUT: begin
                // an accepted push is written as its result transfers
                if (i_ready) begin
                    n_st = S_IDLE;
                    if (r_acc && r_cmd.action == ACT_PUSH_APP) begin
                        a_we = 1'b1; n_awr = inc(r_awr); n_acnt = r_acnt + 1'b1;
                    end else if (r_acc) begin
                        d_we = 1'b1; n_dwr = inc(r_dwr); n_dcnt = r_dcnt + 1'b1;
                    end
                end
            end
            S_GREAD: begin
                // gather one debug entry per pass
                if (r_dcnt != '0 && !r_prdy) n_st = S_GWAIT;
                else n_st = S_PEVAL;
            end
            S_GWAIT: n_st = S_GEVAL;
            S_GEVAL: begin
                n_drd = inc(r_drd); n_dcnt = r_dcnt - 1'b1;
                if (!d_rd[10]) begin
                    if (32'(r_plen) < PacketMax) p_we = 1'b1;
                    if (32'(r_plen) <= PacketMax) n_plen = r_plen + 1'b1;
                end else if (32'(r_plen) <= PacketMax) begin
                    n_pdel = d_rd[9:0]; n_prdy = 1'b1;
                    n_pad = (32'(r_pad) > 32'(r_plen)) ? r_pad - 10'(r_plen) - 10'd1 : '0;
                end else begin
                    n_plen = '0; n_drop = 1'b1;
                end
                n_st = S_GREAD;
            end
            S_PREAD: n_st = S_PWAIT;
            S_PWAIT: n_st = S_PEVAL;
            default: begin // S_PEVAL: RAM outputs valid for r_ard and r_sidx
                n_st = S_OUT;
                if (r_ph == PH_IDLE || r_ph == PH_APPOWED) begin
                    if (r_ph == PH_IDLE && !r_owed) begin
                        if (app_go) begin
                            n_ov = 1'b1;
                            if (r_cur) begin
                                n_cur = 1'b0; n_pad = pad_d; n_ph = PH_APPOWED;
                                n_ob = SEL_APP;
                            end else begin
                                n_ard = inc(r_ard); n_acnt = r_acnt - 1'b1;
                                n_pad = pad_d;
                                n_ob = a_rd;
                                if (needs_esc(a_rd)) begin
                                    n_ob = ESC_CHAR; n_pend = {1'b1, ~a_rd};
                                end
                            end
                        end else if (r_prdy) begin
                            n_ov = 1'b1; n_ph = PH_PAD; n_st = S_PREAD;
                        end
                    end else begin
                        n_ov = 1'b1; n_ard = inc(r_ard); n_acnt = r_acnt - 1'b1;
                        n_pad = pad_d; n_ob = a_rd;
                        if (needs_esc(a_rd)) begin
                            n_ob = ESC_CHAR; n_pend = {1'b1, ~a_rd};
                        end
                    end
                end else begin
                    n_ov = 1'b1;
                    if (r_ph == PH_PAD && r_pad != 10'd0) begin
                        n_cur = 1'b0; n_pad = pad_d; n_ob = SEL_APP;
                    end else if ((r_ph == PH_PAD || r_ph == PH_START) && !r_cur) begin
                        n_ph = PH_BODY; n_sidx = '0; n_cur = 1'b1; n_ob = SEL_DBG;
                    end else if ((r_ph == PH_PAD || r_ph == PH_START) && r_sidx != '0) begin
                        n_ph = PH_BODY; n_sidx = '0; n_st = S_PREAD;
                    end else if (r_ph != PH_TRAIL && r_sidx < r_plen
                                 && 32'(r_sidx) < PacketMax) begin
                        n_ph = PH_BODY; n_sidx = r_sidx + 1'b1; n_ob = p_rd;
                        if (needs_esc(p_rd)) begin
                            n_ob = ESC_CHAR; n_pend = {1'b1, ~p_rd};
                        end
                    end else begin
                        n_pad = (r_pdel != 10'd0) ? r_pdel - 10'd1 : 10'd0;
                        n_prdy = 1'b0; n_plen = '0; n_ph = PH_IDLE; n_sidx = '0;
                        n_cur = (r_dcnt != '0);
                        n_ob = (r_dcnt != '0) ? SEL_DBG : SEL_APP;
                    end
                end
            end
        endcase
    end

    a_one_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_accepted && o_out_valid)) else $error("push and pull result");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_acnt) <= QueueDepth && 32'(r_dcnt) <= QueueDepth) else $error("count");
    a_plen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_plen) <= PacketMax + 1) else $error("packet length");
endmodule
`default_nettype wire

@@ design/serial_stream_mux_tx.sv @@
// Sequencing: a push goes from idle straight to its result; a pull may first
//   gather debug entries, one read, wait and evaluate pass each, and a packet
//   that starts sending adds a packet store read, wait and evaluate pass. The back
//   end takes a new command only when idle, after the previous result transfers.
// Reset: synchronous active-low i_rst_n clears pointers, counts, phases;
//   queue memories are not cleared, counts keep unwritten entries unread.
// ----------------------------------------------------------------------------
// serial_stream_mux_tx: two-stream serial multiplexer, transmit side
// Front queue takes actions; back end runs the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module serial_stream_mux_tx (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [1:0] i_action,
    input  wire logic [7:0] i_data_byte,
    input  wire logic [9:0] i_reply_delay,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_accepted,
    output logic            o_out_valid,
    output logic [7:0]      o_out_byte,
    output logic            o_packet_dropped
);
    import ssm_pkg::*;

    t_cmd in_cmd, q_cmd;
    logic q_valid, q_ready;

    // decode the raw action code into the command struct
    assign in_cmd.action = t_action'(i_action);
    assign in_cmd.data   = i_data_byte;
    assign in_cmd.delay  = i_reply_delay;

    ssm_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_cmd(in_cmd),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd));

    // back end: queues, gathering, escape and pad sequencing
    ssm_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .o_valid, .i_ready, .o_accepted, .o_out_valid, .o_out_byte,
        .o_packet_dropped);
endmodule
`default_nettype wire

@@ verif/tb_serial_stream_mux_tx.sv @@
// ----------------------------------------------------------------------------
// tb_serial_stream_mux_tx: self-checking bench for the serial stream mux tx
// Drives random push/end/pull sequences with random idling on both sides and
// compares every result against a behavioral predictor of the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

// Expected results of the transmitter, kept in transfer order.
class mux_tx_scoreboard;
    typedef struct packed {
        logic       accepted;
        logic       out_valid;
        logic [7:0] out_byte;
        logic       dropped;
    } t_result;

    t_result    pending_results[$];
    int         error_count;

    // predictor state
    logic [7:0] app_mem[256];
    int         app_rd, app_wr, app_cnt;
    logic [10:0] dbg_mem[256];
    int         dbg_rd, dbg_wr, dbg_cnt;
    logic [7:0] pkt_mem[32];
    int         pkt_len, pkt_delay, pad_left, send_idx;
    bit         pkt_ready, on_debug;
    logic [8:0] esc_hold;
    ssm_pkg::t_phase phase;

    function new();
        app_rd = 0; app_wr = 0; app_cnt = 0;
        dbg_rd = 0; dbg_wr = 0; dbg_cnt = 0;
        pkt_len = 0; pkt_delay = 0; pad_left = 0; send_idx = 0;
        pkt_ready = 0; on_debug = 0; esc_hold = '0;
        phase = ssm_pkg::PH_IDLE;
        error_count = 0;
    endfunction

    function void pad_step();
        if (pad_left > 0) pad_left--;
    endfunction

    // first raw byte of a data byte; the escaped half is held back
    function logic [7:0] encode_byte(input logic [7:0] b);
        if (b == ssm_pkg::SEL_APP || b == ssm_pkg::SEL_DBG || b == ssm_pkg::ESC_CHAR) begin
            esc_hold = {1'b1, ~b};
            return ssm_pkg::ESC_CHAR;
        end
        return b;
    endfunction

    function logic [7:0] app_take();
        logic [7:0] v;
        v = app_mem[app_rd];
        app_rd = (app_rd + 1) % 256;
        app_cnt--;
        return v;
    endfunction

    // move debug entries into the packet store; 1 if a packet got dropped
    function bit collect_packet();
        logic [10:0] e;
        bit dropped;
        dropped = 0;
        while (dbg_cnt > 0 && !pkt_ready) begin
            e = dbg_mem[dbg_rd];
            dbg_rd = (dbg_rd + 1) % 256;
            dbg_cnt--;
            if (!e[10]) begin
                if (pkt_len < 32) pkt_mem[pkt_len] = e[7:0];
                if (pkt_len <= 32) pkt_len++;
            end else if (pkt_len <= 32) begin
                pkt_delay = e[9:0];
                pkt_ready = 1;
                pad_left = (pad_left > pkt_len) ? pad_left - pkt_len - 1 : 0;
            end else begin
                pkt_len = 0;
                dropped = 1;
            end
        end
        return dropped;
    endfunction

    function logic [7:0] packet_byte();
        if (phase == ssm_pkg::PH_PAD) begin
            if (pad_left > 0) begin
                on_debug = 0;
                pad_step();
                return ssm_pkg::SEL_APP;
            end
            phase = ssm_pkg::PH_START;
        end
        if (phase == ssm_pkg::PH_START) begin
            phase = ssm_pkg::PH_BODY;
            send_idx = 0;
            if (!on_debug) begin
                on_debug = 1;
                return ssm_pkg::SEL_DBG;
            end
        end
        if (phase == ssm_pkg::PH_BODY) begin
            if (send_idx < pkt_len && send_idx < 32) begin
                send_idx++;
                return encode_byte(pkt_mem[send_idx - 1]);
            end
            phase = ssm_pkg::PH_TRAIL;
        end
        pad_left = pkt_delay;
        pkt_ready = 0;
        pkt_len = 0;
        phase = ssm_pkg::PH_IDLE;
        send_idx = 0;
        pad_step();
        on_debug = (dbg_cnt > 0);
        return on_debug ? ssm_pkg::SEL_DBG : ssm_pkg::SEL_APP;
    endfunction

    function void note_transfer(input ssm_pkg::t_action act, input logic [7:0] data,
                                input logic [9:0] delay);
        t_result r;
        r = '0;
        case (act)
            ssm_pkg::ACT_PUSH_APP: begin
                if (app_cnt < 256) begin
                    app_mem[app_wr] = data;
                    app_wr = (app_wr + 1) % 256;
                    app_cnt++;
                    r.accepted = 1;
                end
            end
            ssm_pkg::ACT_PUSH_DBG, ssm_pkg::ACT_END_PKT: begin
                if (dbg_cnt < 256) begin
                    dbg_mem[dbg_wr] = (act == ssm_pkg::ACT_PUSH_DBG) ? {3'b000, data}
                                                                    : {1'b1, delay};
                    dbg_wr = (dbg_wr + 1) % 256;
                    dbg_cnt++;
                    r.accepted = 1;
                end
            end
            default: begin
                if (esc_hold[8]) begin
                    r.out_valid = 1;
                    r.out_byte = esc_hold[7:0];
                    esc_hold = '0;
                end else if (phase == ssm_pkg::PH_APPOWED) begin
                    phase = ssm_pkg::PH_IDLE;
                    r.out_valid = 1;
                    r.out_byte = encode_byte(app_take());
                    pad_step();
                end else if (phase != ssm_pkg::PH_IDLE) begin
                    r.out_valid = 1;
                    r.out_byte = packet_byte();
                end else begin
                    r.dropped = collect_packet();
                    if (app_cnt > 0 && (pad_left > 0 || !pkt_ready)) begin
                        r.out_valid = 1;
                        if (on_debug) begin
                            on_debug = 0;
                            pad_step();
                            phase = ssm_pkg::PH_APPOWED;
                            r.out_byte = ssm_pkg::SEL_APP;
                        end else begin
                            r.out_byte = encode_byte(app_take());
                            pad_step();
                        end
                    end else if (pkt_ready) begin
                        r.out_valid = 1;
                        phase = ssm_pkg::PH_PAD;
                        r.out_byte = packet_byte();
                    end
                end
            end
        endcase
        pending_results.push_back(r);
    endfunction

    function void check_result(input t_result got);
        t_result want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result acc=%b vld=%b byte=%02h drop=%b", $time,
                     got.accepted, got.out_valid, got.out_byte, got.dropped);
            error_count++;
            return;
        end
        want = pending_results.pop_front();
        if (got !== want) begin
            $display("%0t: mismatch expected acc=%b vld=%b byte=%02h drop=%b", $time,
                     want.accepted, want.out_valid, want.out_byte, want.dropped);
            $display("%0t:          actual   acc=%b vld=%b byte=%02h drop=%b", $time,
                     got.accepted, got.out_valid, got.out_byte, got.dropped);
            error_count++;
        end
    endfunction
endclass

module tb_serial_stream_mux_tx;
    import ssm_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [1:0] i_action;
    logic [7:0] i_data_byte;
    logic [9:0] i_reply_delay;
    logic       o_valid;
    logic       i_ready;
    logic       o_accepted;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_packet_dropped;

    mux_tx_scoreboard sb;
    bit stimulus_done;

    serial_stream_mux_tx dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_data_byte      (i_data_byte),
        .i_reply_delay    (i_reply_delay),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_accepted       (o_accepted),
        .o_out_valid      (o_out_valid),
        .o_out_byte       (o_out_byte),
        .o_packet_dropped (o_packet_dropped)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Gap length: mostly zero or short, now and then a long pause.
    function automatic int gap_length(input int bias);
        int r;
        r = $urandom_range(0, 99);
        if (r < bias) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one item and hold it until the transfer happens.
    // The predictor is updated at the accepting edge, before the result can appear.
    // Valid stays high afterwards; a gap or the caller drops it.
    task automatic send_item(input t_action act, input logic [7:0] data,
                             input logic [9:0] delay, input int bias);
        int gap;
        gap = gap_length(bias);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= act;
        i_data_byte   <= data;
        i_reply_delay <= delay;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_transfer(act, data, delay);
    endtask

    task automatic push_packet(input int len, input int delay, input int bias);
        for (int k = 0; k < len; k++)
            send_item(ACT_PUSH_DBG, 8'($urandom_range(0, 255)), 10'd0, bias);
        send_item(ACT_END_PKT, 8'($urandom), 10'(delay), bias);
    endtask

    // Byte skewed toward the select and escape codes.
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(8'hFC, 8'hFF));
        return 8'($urandom);
    endfunction

    // Result side: random stalls, checking at each result transfer.
    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 5) == 0) begin
                stall = gap_length(0);
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            if (o_valid)
                sb.check_result({o_accepted, o_out_valid, o_out_byte, o_packet_dropped});
        end
    end

    initial begin
        int   count;
        int   bias;
        int   r;
        sb = new();
        stimulus_done = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_action      = ACT_PULL;
        i_data_byte   = '0;
        i_reply_delay = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty pull, escaped app bytes, a packet with the debug select
        // and escape bytes, the extreme delays, and an oversized drop.
        send_item(ACT_PULL, 8'hFF, 10'h3FF, 100);
        send_item(ACT_PUSH_APP, 8'h00, 10'h3FF, 100);
        send_item(ACT_PUSH_APP, 8'hFE, 10'h000, 100);
        send_item(ACT_PUSH_APP, 8'hFF, 10'h000, 100);
        send_item(ACT_PUSH_DBG, 8'hFD, 10'h000, 100);
        send_item(ACT_PUSH_DBG, 8'hFC, 10'h000, 100);
        send_item(ACT_END_PKT, 8'h00, 10'h3FF, 100);
        repeat (8) send_item(ACT_PULL, 8'h00, 10'h000, 100);
        push_packet(0, 0, 100);
        push_packet(33, 1, 100);
        repeat (4) send_item(ACT_PULL, 8'h00, 10'h000, 100);

        // Hold off until everything in flight has come back.
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);

        // Fill the application queue past full to hit refusal.
        for (int k = 0; k < 258; k++) send_item(ACT_PUSH_APP, pick_byte(), 10'd0, 90);
        // Debug queue past full too.
        for (int k = 0; k < 258; k++)
            send_item(k % 7 == 6 ? ACT_END_PKT : ACT_PUSH_DBG, pick_byte(),
                      10'($urandom_range(0, 3)), 90);
        // Drain with pulls, then random traffic.
        for (int k = 0; k < 700; k++) send_item(ACT_PULL, 8'h00, 10'h000, 80);

        count = 0;
        while (count < 520) begin
            bias = ($urandom_range(0, 3) == 0) ? 100 : 60;
            r = $urandom_range(0, 99);
            if (r < 30) begin
                send_item(ACT_PUSH_APP, pick_byte(), 10'($urandom), bias);
                count++;
            end else if (r < 45) begin
                int len;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36)
                                                  : $urandom_range(0, 6);
                push_packet(len, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                               : $urandom_range(0, 8), bias);
                count += len + 1;
            end else if (r < 50) begin
                send_item(t_action'($urandom_range(1, 2)), pick_byte(),
                          10'($urandom), bias);
                count++;
            end else begin
                send_item(ACT_PULL, 8'($urandom), 10'($urandom), bias);
                count++;
            end
        end
        // Drain leftovers so queued packets get sent.
        repeat (80) send_item(ACT_PULL, 8'h00, 10'h000, 90);
        i_valid <= 1'b0;
        stimulus_done = 1;
    end

    initial begin
        @(posedge i_clk);
        while (!stimulus_done || sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.error_count == 0 && sb.pending_results.size() == 0)
            $display("** serial_stream_mux_tx: PASSED **");
        else
            $display("** serial_stream_mux_tx: FAILED **");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #20000000;
        $display("** serial_stream_mux_tx: FAILED **");
        $finish;
    end
endmodule

`default_nettype wire
